@@ src/pedsd_pkg.sv @@
package pedsd_pkg;

  localparam int AccelW   = 16;
  localparam int AngleW   = 16;
  localparam int ThrAngW  = 15;
  localparam int TimeW    = 32;
  localparam int MsCfgW   = 16;
  localparam int CountW   = 16;
  localparam int ShownW   = 17;
  localparam int SquareW  = 32;
  localparam int AddrW    = 5;
  localparam int DataW    = 32;

  localparam logic [AccelW-1:0]  AccelThrReset   = 16'd5000;
  localparam logic [ThrAngW-1:0] PitchThrReset   = 15'd3277;
  localparam logic [ThrAngW-1:0] RollThrReset    = 15'd15565;
  localparam logic [MsCfgW-1:0]  RefractoryReset = 16'd500;
  localparam logic [MsCfgW-1:0]  HoldoffReset    = 16'd1000;

  localparam logic [CountW-1:0]  CountMax = {CountW{1'b1}};

  // register index, taken from paddr[4:2]
  localparam logic [2:0] REG_ACCEL_THR  = 3'd0;
  localparam logic [2:0] REG_PITCH_THR  = 3'd1;
  localparam logic [2:0] REG_ROLL_THR   = 3'd2;
  localparam logic [2:0] REG_REFRACTORY = 3'd3;
  localparam logic [2:0] REG_HOLDOFF    = 3'd4;

endpackage

@@ src/pedsd_if.sv @@
interface pedsd_sample_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [pedsd_pkg::AccelW-1:0]  accel_x;
  logic signed [pedsd_pkg::AccelW-1:0]  accel_y;
  logic signed [pedsd_pkg::AccelW-1:0]  accel_z;
  logic signed [pedsd_pkg::AngleW-1:0]  pitch;
  logic signed [pedsd_pkg::AngleW-1:0]  roll;
  logic        [pedsd_pkg::TimeW-1:0]   now_ms;

  modport source (output valid, accel_x, accel_y, accel_z, pitch, roll, now_ms,
                  input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, pitch, roll, now_ms,
                  output ready);
endinterface

interface pedsd_result_if;
  logic                               valid;
  logic                               ready;
  logic                               counting;
  logic                               step_seen;
  logic                               ignored;
  logic [pedsd_pkg::ShownW-1:0]       steps_shown;
  logic [pedsd_pkg::TimeW-1:0]        elapsed_ms;

  modport source (output valid, counting, step_seen, ignored, steps_shown, elapsed_ms,
                  input ready);
  modport sink   (input valid, counting, step_seen, ignored, steps_shown, elapsed_ms,
                  output ready);
endinterface

@@ src/pedometer_step_detector.sv @@
// Sample path: input register, then result register; squares, compares and
//   the step/holdoff update all sit between the two registers.
// Throughput: one sample per cycle; a stalled result holds the input register,
//   and input ready follows result ready within the same cycle.
// Reset (rst, synchronous): both registers empty, all tracking state cleared,
//   configuration registers back to their default thresholds.
module pedometer_step_detector (
  input  logic                          clk,
  input  logic                          rst,
  pedsd_sample_if.sink                  sample,
  pedsd_result_if.source                result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pedsd_pkg::AddrW-1:0]   paddr,
  input  logic [pedsd_pkg::DataW-1:0]   pwdata,
  output logic [pedsd_pkg::DataW-1:0]   prdata,
  output logic                          pready
);

  function automatic logic [pedsd_pkg::AngleW-1:0] abs16(
      input logic signed [pedsd_pkg::AngleW-1:0] v);
    return v[pedsd_pkg::AngleW-1] ? pedsd_pkg::AngleW'(-v) : $unsigned(v);
  endfunction

  function automatic logic [pedsd_pkg::SquareW-1:0] square16(
      input logic signed [pedsd_pkg::AccelW-1:0] v);
    logic [pedsd_pkg::SquareW-1:0] m;
    m = pedsd_pkg::SquareW'(abs16(v));
    return m * m;
  endfunction

  // configuration
  logic [pedsd_pkg::AccelW-1:0]  accel_threshold;
  logic [pedsd_pkg::ThrAngW-1:0] pitch_threshold;
  logic [pedsd_pkg::ThrAngW-1:0] roll_threshold;
  logic [pedsd_pkg::MsCfgW-1:0]  refractory_ms;
  logic [pedsd_pkg::MsCfgW-1:0]  toggle_holdoff_ms;
  logic [pedsd_pkg::SquareW-1:0] thr2;
  logic                          cfg_wr;
  logic [2:0]                    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_threshold   <= pedsd_pkg::AccelThrReset;
      pitch_threshold   <= pedsd_pkg::PitchThrReset;
      roll_threshold    <= pedsd_pkg::RollThrReset;
      refractory_ms     <= pedsd_pkg::RefractoryReset;
      toggle_holdoff_ms <= pedsd_pkg::HoldoffReset;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        pedsd_pkg::REG_ACCEL_THR:  accel_threshold   <= pwdata[15:0];
        pedsd_pkg::REG_PITCH_THR:  pitch_threshold   <= pwdata[14:0];
        pedsd_pkg::REG_ROLL_THR:   roll_threshold    <= pwdata[14:0];
        pedsd_pkg::REG_REFRACTORY: refractory_ms     <= pwdata[15:0];
        pedsd_pkg::REG_HOLDOFF:    toggle_holdoff_ms <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      pedsd_pkg::REG_ACCEL_THR:  prdata = 32'(accel_threshold);
      pedsd_pkg::REG_PITCH_THR:  prdata = 32'(pitch_threshold);
      pedsd_pkg::REG_ROLL_THR:   prdata = 32'(roll_threshold);
      pedsd_pkg::REG_REFRACTORY: prdata = 32'(refractory_ms);
      pedsd_pkg::REG_HOLDOFF:    prdata = 32'(toggle_holdoff_ms);
      default:                   prdata = '0;
    endcase
  end

  assign thr2 = pedsd_pkg::SquareW'(accel_threshold) * pedsd_pkg::SquareW'(accel_threshold);

  // handshake: input register and result register
  logic va, vo;
  logic rdy_a, rdy_o;
  logic fire_a;

  assign rdy_o = !vo || result.ready;
  assign rdy_a = !va || rdy_o;
  assign sample.ready = rdy_a;
  assign fire_a = va && rdy_o;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vo <= 1'b0;
    end else begin
      if (rdy_a) va <= sample.valid;
      if (rdy_o) vo <= va;
    end
  end

  // input register
  logic signed [pedsd_pkg::AccelW-1:0] a_x, a_y, a_z;
  logic signed [pedsd_pkg::AngleW-1:0] a_pitch, a_roll;
  logic        [pedsd_pkg::TimeW-1:0]  a_now;

  always_ff @(posedge clk) begin
    if (rdy_a && sample.valid) begin
      a_x     <= sample.accel_x;
      a_y     <= sample.accel_y;
      a_z     <= sample.accel_z;
      a_pitch <= sample.pitch;
      a_roll  <= sample.roll;
      a_now   <= sample.now_ms;
    end
  end

  // threshold compares; sum of three squares stays below 2^32
  logic [pedsd_pkg::SquareW-1:0] sq_x, sq_y, sq_z, mag2;
  logic                          above, pitch_ok, roll_hit;

  assign sq_x     = square16(a_x);
  assign sq_y     = square16(a_y);
  assign sq_z     = square16(a_z);
  assign mag2     = sq_x + sq_y + sq_z;
  assign above    = mag2 > thr2;
  assign pitch_ok = abs16(a_pitch) > pedsd_pkg::AngleW'(pitch_threshold);
  assign roll_hit = abs16(a_roll) > pedsd_pkg::AngleW'(roll_threshold);

  // tracking state
  logic                         counting_on, was_above, holdoff_active;
  logic [pedsd_pkg::CountW-1:0] step_total;
  logic [pedsd_pkg::TimeW-1:0]  last_step_ms, first_step_ms, elapsed_time;
  logic [pedsd_pkg::TimeW-1:0]  holdoff_start_ms;

  logic                         counting_on_next, was_above_next, holdoff_active_next;
  logic [pedsd_pkg::CountW-1:0] step_total_next;
  logic [pedsd_pkg::TimeW-1:0]  last_step_ms_next, first_step_ms_next;
  logic [pedsd_pkg::TimeW-1:0]  elapsed_time_next, holdoff_start_ms_next;
  logic                         ign, step;

  logic [pedsd_pkg::TimeW-1:0]  since_holdoff, since_step;
  logic                         clear;
  logic [pedsd_pkg::CountW-1:0] total_base;
  logic [pedsd_pkg::TimeW-1:0]  first_base;

  assign since_holdoff = a_now - holdoff_start_ms;
  assign since_step    = a_now - last_step_ms;

  always_comb begin
    ign = holdoff_active && (since_holdoff < 32'(toggle_holdoff_ms));

    counting_on_next      = counting_on;
    was_above_next        = was_above;
    holdoff_active_next   = holdoff_active;
    holdoff_start_ms_next = holdoff_start_ms;
    step_total_next       = step_total;
    last_step_ms_next     = last_step_ms;
    first_step_ms_next    = first_step_ms;
    elapsed_time_next     = elapsed_time;
    step                  = 1'b0;
    clear                 = 1'b0;
    total_base            = step_total;
    first_base            = first_step_ms;

    if (!ign) begin
      holdoff_active_next = 1'b0;
      if (roll_hit) begin
        counting_on_next      = !counting_on;
        clear                 = !counting_on;
        holdoff_active_next   = 1'b1;
        holdoff_start_ms_next = a_now;
      end
      // switching on starts a fresh session
      if (clear) begin
        total_base        = '0;
        first_base        = '0;
        elapsed_time_next = '0;
      end
      step = counting_on_next && above && !was_above && pitch_ok
             && (since_step > 32'(refractory_ms));
      step_total_next    = (step && total_base != pedsd_pkg::CountMax) ?
                           total_base + 1'b1 : total_base;
      first_step_ms_next = (step && total_base == '0) ? a_now : first_base;
      if (step) last_step_ms_next = a_now;
      if (counting_on_next && step_total_next != '0) begin
        elapsed_time_next = a_now - first_step_ms_next;
      end
      was_above_next = above;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counting_on      <= 1'b0;
      was_above        <= 1'b0;
      holdoff_active   <= 1'b0;
      holdoff_start_ms <= '0;
      step_total       <= '0;
      last_step_ms     <= '0;
      first_step_ms    <= '0;
      elapsed_time     <= '0;
    end else if (fire_a) begin
      counting_on      <= counting_on_next;
      was_above        <= was_above_next;
      holdoff_active   <= holdoff_active_next;
      holdoff_start_ms <= holdoff_start_ms_next;
      step_total       <= step_total_next;
      last_step_ms     <= last_step_ms_next;
      first_step_ms    <= first_step_ms_next;
      elapsed_time     <= elapsed_time_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (fire_a) begin
      result.counting    <= counting_on_next;
      result.step_seen   <= step;
      result.ignored     <= ign;
      result.steps_shown <= {step_total_next, 1'b0};
      result.elapsed_ms  <= elapsed_time_next;
    end
  end

  assign result.valid = vo;

  // checks
  a_ign_no_step: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.ignored |-> !result.step_seen)
    else $error("step reported on a sample inside the holdoff");

  a_step_needs_counting: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.step_seen |-> result.counting)
    else $error("step reported while counting is off");

  a_ign_holds_count: assert property (@(posedge clk) disable iff (rst)
    fire_a && ign |=> $stable(step_total) && $stable(counting_on))
    else $error("ignored sample changed the count or counting state");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !vo && !va)
    else $error("pipeline not empty after reset");

endmodule

@@ tb/pedsd_checker.sv @@
module pedsd_checker
  import pedsd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  pedsd_sample_if            smp,
  pedsd_result_if            res,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [AddrW-1:0]   paddr,
  input  logic [DataW-1:0]   pwdata,
  output int                 mismatches,
  output int                 pending,
  output int                 results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic              counting;
    logic              step_seen;
    logic              ignored;
    logic [ShownW-1:0] steps_shown;
    logic [TimeW-1:0]  elapsed_ms;
  } outcome_t;

  outcome_t outcome_q[$];

  logic [AccelW-1:0]  cfg_accel;
  logic [ThrAngW-1:0] cfg_pitch;
  logic [ThrAngW-1:0] cfg_roll;
  logic [MsCfgW-1:0]  cfg_refr;
  logic [MsCfgW-1:0]  cfg_hold;

  logic              st_counting;
  logic              st_above;
  logic [CountW-1:0] st_total;
  logic [TimeW-1:0]  st_last;
  logic [TimeW-1:0]  st_first;
  logic [TimeW-1:0]  st_elapsed;
  logic [TimeW-1:0]  st_hold_start;
  logic              st_hold_on;

  function automatic logic [16:0] mag(input logic signed [15:0] v);
    logic [16:0] w;
    w = {v[15], v};
    return v[15] ? (~w + 17'd1) : w;
  endfunction

  function automatic logic [33:0] sq(input logic signed [15:0] v);
    logic [16:0] m;
    m = mag(v);
    return {17'd0, m} * {17'd0, m};
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (mismatches < 40)
      $display("%0t mismatch: %s got %0h want %0h", $time, what, got, want);
    mismatches++;
  endtask

  // one sample through the step/holdoff rules, result queued
  task automatic track_step(input logic signed [AccelW-1:0] ax, ay, az,
                            input logic signed [AngleW-1:0] pt, rl,
                            input logic [TimeW-1:0] now);
    logic [33:0]      energy;
    logic [33:0]      limit2;
    logic [TimeW-1:0] gap;
    logic             above;
    logic             stepped;
    logic             skipped;
    outcome_t         o;
    stepped = 1'b0;
    skipped = 1'b0;
    if (st_hold_on) begin
      gap = now - st_hold_start;
      if (gap < {16'd0, cfg_hold}) skipped = 1'b1;
      else st_hold_on = 1'b0;
    end
    if (!skipped) begin
      energy = sq(ax) + sq(ay) + sq(az);
      limit2 = {18'd0, cfg_accel} * {18'd0, cfg_accel};
      above  = energy > limit2;
      if (mag(rl) > {2'b00, cfg_roll}) begin
        if (st_counting) begin
          st_counting = 1'b0;
        end else begin
          st_counting = 1'b1;
          st_total    = '0;
          st_first    = '0;
          st_elapsed  = '0;
        end
        st_hold_on    = 1'b1;
        st_hold_start = now;
      end
      if (st_counting) begin
        gap = now - st_last;
        if (above && !st_above && mag(pt) > {2'b00, cfg_pitch} &&
            gap > {16'd0, cfg_refr}) begin
          stepped = 1'b1;
          if (st_total != CountMax) begin
            st_total = st_total + 1'b1;
            if (st_total == 1) st_first = now;
          end
          st_last = now;
        end
        if (st_total != 0) st_elapsed = now - st_first;
      end
      st_above = above;
    end
    o.counting    = st_counting;
    o.step_seen   = stepped;
    o.ignored     = skipped;
    o.steps_shown = {st_total, 1'b0};
    o.elapsed_ms  = st_elapsed;
    outcome_q.push_back(o);
  endtask

  always @(posedge clk) begin : watch
    outcome_t want;
    if (rst) begin
      outcome_q.delete();
      cfg_accel     = AccelThrReset;
      cfg_pitch     = PitchThrReset;
      cfg_roll      = RollThrReset;
      cfg_refr      = RefractoryReset;
      cfg_hold      = HoldoffReset;
      st_counting   = 1'b0;
      st_above      = 1'b0;
      st_total      = '0;
      st_last       = '0;
      st_first      = '0;
      st_elapsed    = '0;
      st_hold_start = '0;
      st_hold_on    = 1'b0;
      mismatches    = 0;
      results_seen  = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[AddrW-1:2])
          REG_ACCEL_THR:  cfg_accel = pwdata[AccelW-1:0];
          REG_PITCH_THR:  cfg_pitch = pwdata[ThrAngW-1:0];
          REG_ROLL_THR:   cfg_roll  = pwdata[ThrAngW-1:0];
          REG_REFRACTORY: cfg_refr  = pwdata[MsCfgW-1:0];
          REG_HOLDOFF:    cfg_hold  = pwdata[MsCfgW-1:0];
          default: ;
        endcase
      end
      if (res.valid && res.ready) begin
        results_seen++;
        if (outcome_q.size() == 0) begin
          flag_mismatch("result with nothing pending", 32'd0, 32'd0);
        end else begin
          want = outcome_q.pop_front();
          if (res.counting !== want.counting)
            flag_mismatch("counting", 32'(res.counting), 32'(want.counting));
          if (res.step_seen !== want.step_seen)
            flag_mismatch("step_seen", 32'(res.step_seen), 32'(want.step_seen));
          if (res.ignored !== want.ignored)
            flag_mismatch("ignored", 32'(res.ignored), 32'(want.ignored));
          if (res.steps_shown !== want.steps_shown)
            flag_mismatch("steps_shown", 32'(res.steps_shown),
                          32'(want.steps_shown));
          if (res.elapsed_ms !== want.elapsed_ms)
            flag_mismatch("elapsed_ms", res.elapsed_ms, want.elapsed_ms);
        end
      end
      if (smp.valid && smp.ready)
        track_step(smp.accel_x, smp.accel_y, smp.accel_z, smp.pitch, smp.roll,
                   smp.now_ms);
    end
    pending = outcome_q.size();
  end

endmodule

@@ tb/tb_top.sv @@
module tb_top;
  import pedsd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [AccelW-1:0] ax;
    logic signed [AccelW-1:0] ay;
    logic signed [AccelW-1:0] az;
    logic signed [AngleW-1:0] pt;
    logic signed [AngleW-1:0] rl;
    logic [TimeW-1:0]         now;
  } sample_t;

  localparam int AngleMax = 25736;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic pready;
  logic sink_ready = 1'b0;
  logic idle_on = 1'b1;

  int mismatches;
  int pending;
  int results_seen;
  int sent_count = 0;

  // stimulus-side copy of the thresholds, for shaping only
  int sh_accel = 5000;
  int sh_pitch = 3277;
  int sh_roll  = 15565;
  logic [TimeW-1:0] now_clock = '0;

  pedsd_sample_if sample_bus ();
  pedsd_result_if result_bus ();

  assign result_bus.ready = sink_ready;

  pedometer_step_detector dut (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample_bus),
    .result  (result_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  pedsd_checker checker_inst (
    .clk          (clk),
    .rst          (rst),
    .smp          (sample_bus),
    .res          (result_bus),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .mismatches   (mismatches),
    .pending      (pending),
    .results_seen (results_seen)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    sink_ready <= !idle_on || ($urandom_range(0, 99) >= 15);
  end

  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // psel/penable stay up after the transfer; the caller drops them once
  task automatic reg_write(input logic [2:0] idx, input logic [DataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  task automatic configure(input int accel, input int pitch, input int roll,
                           input int refr, input int hold, input bit spare);
    reg_write(REG_ACCEL_THR,  {16'($urandom()), 16'(accel)});
    reg_write(REG_PITCH_THR,  {17'($urandom()), 15'(pitch)});
    reg_write(REG_ROLL_THR,   {17'($urandom()), 15'(roll)});
    reg_write(REG_REFRACTORY, {16'($urandom()), 16'(refr)});
    reg_write(REG_HOLDOFF,    {16'($urandom()), 16'(hold)});
    if (spare) begin
      // indexes past the register list must be ignored
      for (int k = 1; k <= 3; k++) reg_write(REG_HOLDOFF + 3'(k), $urandom());
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    sh_accel = accel;
    sh_pitch = pitch;
    sh_roll  = roll;
  endtask

  task automatic send_sample(input sample_t s);
    if (idle_on && $urandom_range(0, 99) < 10) begin
      sample_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    sample_bus.valid   <= 1'b1;
    sample_bus.accel_x <= s.ax;
    sample_bus.accel_y <= s.ay;
    sample_bus.accel_z <= s.az;
    sample_bus.pitch   <= s.pt;
    sample_bus.roll    <= s.rl;
    sample_bus.now_ms  <= s.now;
    @(posedge clk);
    while (!(sample_bus.valid && sample_bus.ready)) @(posedge clk);
    sent_count++;
  endtask

  task automatic put(input int ax, input int ay, input int az, input int pt,
                     input int rl, input logic [TimeW-1:0] now);
    sample_t s;
    s.ax  = 16'(ax);
    s.ay  = 16'(ay);
    s.az  = 16'(az);
    s.pt  = 16'(pt);
    s.rl  = 16'(rl);
    s.now = now;
    send_sample(s);
  endtask

  function automatic logic signed [15:0] signed_mag(input int m);
    logic [15:0] u;
    u = m[15:0];
    return $urandom_range(0, 1) ? -u : u;
  endfunction

  task automatic shape_sample(output sample_t s);
    int pick;
    int lim;
    int hi;
    logic signed [15:0] tmp;
    pick = $urandom_range(0, 99);
    if (pick < 2) now_clock = $urandom();
    else if (pick < 3) now_clock = 32'hFFFF_FFFF - $urandom_range(0, 3000);
    else if (pick < 8) now_clock += $urandom_range(0, 70000);
    else now_clock += $urandom_range(0, 400);
    s.now = now_clock;

    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      s.ax = 16'($urandom());
      s.ay = 16'($urandom());
      s.az = 16'($urandom());
    end else if (pick < 55) begin
      // one dominant axis just over the magnitude threshold
      if (sh_accel < 32000) begin
        hi = (sh_accel + 3000 > 32767) ? 32767 : sh_accel + 3000;
        s.ax = signed_mag($urandom_range(sh_accel + 1, hi));
      end else begin
        s.ax = signed_mag($urandom_range(20000, 32767));
      end
      lim = sh_accel / 4;
      s.ay = signed_mag($urandom_range(0, lim));
      s.az = signed_mag($urandom_range(0, lim));
    end else begin
      lim = (sh_accel / 2 > 32767) ? 32767 : sh_accel / 2;
      s.ax = signed_mag($urandom_range(0, lim));
      s.ay = signed_mag($urandom_range(0, lim));
      s.az = signed_mag($urandom_range(0, lim));
    end
    pick = $urandom_range(0, 2);
    if (pick == 1) begin
      tmp = s.ax; s.ax = s.ay; s.ay = tmp;
    end else if (pick == 2) begin
      tmp = s.ax; s.ax = s.az; s.az = tmp;
    end

    pick = $urandom_range(0, 99);
    if (pick < 70 && sh_pitch < AngleMax)
      s.pt = signed_mag($urandom_range(sh_pitch + 1, AngleMax));
    else
      s.pt = signed_mag($urandom_range(0, sh_pitch));

    pick = $urandom_range(0, 99);
    if (pick < 4 && sh_roll < AngleMax) s.rl = signed_mag($urandom_range(sh_roll + 1, AngleMax));
    else if (pick < 6) s.rl = signed_mag(sh_roll);
    else s.rl = signed_mag($urandom_range(0, sh_roll));
  endtask

  task automatic run_random(input int count);
    sample_t s;
    for (int i = 0; i < count; i++) begin
      shape_sample(s);
      send_sample(s);
    end
  endtask

  // block is idle once every queued sample has come back
  task automatic settle();
    sample_bus.valid <= 1'b0;
    while (results_seen < sent_count) @(posedge clk);
  endtask

  initial begin
    rst                <= 1'b1;
    sample_bus.valid   <= 1'b0;
    sample_bus.accel_x <= '0;
    sample_bus.accel_y <= '0;
    sample_bus.accel_z <= '0;
    sample_bus.pitch   <= '0;
    sample_bus.roll    <= '0;
    sample_bus.now_ms  <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed, reset thresholds
    put(0, 0, 0, 0, 0, 0);
    put(32767, -32768, -32768, 25736, 0, 10);     // above while not counting
    put(0, 0, 0, 0, 15565, 20);                   // roll at threshold: no toggle
    put(32767, 0, 0, 25736, 15565, 30);
    put(6000, 0, 0, 25736, -15566, 100);          // toggle on, already above
    put(0, 0, 0, 25736, 0, 500);                  // holdoff
    put(6000, 0, 0, 25736, 0, 1099);              // holdoff, last ms
    put(0, 0, 0, 0, 0, 1100);
    put(5001, 0, 0, 3278, 0, 1700);               // first step
    put(0, 0, 0, 0, 0, 1800);
    put(0, -6000, 0, -25736, 0, 2000);            // refractory
    put(0, 0, 0, 0, 0, 2300);
    put(5000, 0, 0, 25736, 0, 2700);              // magnitude equal: not above
    put(-5001, 0, 0, 3277, 0, 2701);              // pitch equal: no step
    put(0, 0, 0, 0, 0, 2800);
    put(0, 0, -5001, -3278, 0, 2900);
    put(0, 0, 0, 0, 0, 3000);
    put(5001, 0, 0, 25736, 0, 3400);              // gap equals refractory
    put(0, 0, 0, 0, 0, 3401);
    put(5001, 0, 0, 25736, 0, 3401);
    put(0, 0, 0, 0, 25736, 3500);                 // toggle off
    put(0, 0, 0, 0, -25736, 4000);                // ignored, no toggle
    put(6000, 0, 0, 25736, -25736, 4500);         // toggle on and step together
    put(0, 0, 0, 0, 0, 32'hFFFF_FF00);
    put(0, 6000, 0, 25736, 0, 32'hFFFF_FF10);
    put(0, 0, 0, 0, 0, 32'h0000_0100);
    put(0, 0, -32768, 25736, 0, 32'h0000_0300);   // step across the wrap
    settle();

    configure(5000, 3277, 15565, 500, 1000, 1'b1);
    run_random(350);
    settle();

    idle_on = 1'b0;
    configure($urandom_range(2000, 20000), $urandom_range(0, 10000),
              $urandom_range(8000, 25000), $urandom_range(0, 1000),
              $urandom_range(0, 3000), 1'b0);
    run_random(250);
    settle();
    idle_on = 1'b1;

    configure(0, 0, 0, 0, 0, 1'b0);
    run_random(100);
    settle();

    configure(65535, AngleMax, AngleMax, 65535, 65535, 1'b0);
    run_random(100);
    settle();

    for (int p = 0; p < 3; p++) begin
      configure($urandom_range(2000, 20000), $urandom_range(0, 10000),
                $urandom_range(8000, 25000), $urandom_range(0, 1000),
                $urandom_range(0, 3000), p == 1);
      run_random(110);
      settle();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
